[sv/agfc_pkg.sv]
package agfc_pkg;

   // item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_OFFSET = 2'd2;
   localparam logic [1:0] KIND_CANCEL = 2'd3;

   // calibration status codes
   localparam logic [2:0] CAL_IDLE       = 3'd0;
   localparam logic [2:0] CAL_COLLECTING = 3'd1;
   localparam logic [2:0] CAL_DONE       = 3'd2;
   localparam logic [2:0] CAL_MOVED      = 3'd3;
   localparam logic [2:0] CAL_NOT_FLAT   = 3'd4;
   localparam logic [2:0] CAL_CANCELLED  = 3'd5;

   // configuration register indexes
   localparam logic [2:0] REG_SAMPLES  = 3'd0;
   localparam logic [2:0] REG_MAX_DEV  = 3'd1;
   localparam logic [2:0] REG_MIN_GSQ  = 3'd2;
   localparam logic [2:0] REG_MAX_GSQ  = 3'd3;
   localparam logic [2:0] REG_PLAUS    = 3'd4;

   // all-zero report pattern bands, 1/1024 g, inclusive
   localparam int MAIN_PAT_LO = 5213;
   localparam int MAIN_PAT_HI = 5273;
   localparam int EXT_PAT_LO  = 2591;
   localparam int EXT_PAT_HI  = 2652;
   localparam int REST_Y      = -1024;
   localparam int ONE_G       = 1024;
   localparam int HALF_G      = 512;

   // divider remainder width: holds twice the largest count (256)
   localparam int REM_W = 10;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVAL = 6'b000010,
      S_DIV  = 6'b000100,
      S_SQ   = 6'b001000,
      S_CHK  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

endpackage

[sv/agfc_req_if.sv]
interface agfc_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    kind;
   logic [1:0]                    port;
   logic                          sensor;
   logic                          present;
   logic signed [SAMPLE_BITS-1:0] in_x;
   logic signed [SAMPLE_BITS-1:0] in_y;
   logic signed [SAMPLE_BITS-1:0] in_z;

   modport source (output valid, kind, port, sensor, present, in_x, in_y, in_z, input ready);
   modport sink   (input valid, kind, port, sensor, present, in_x, in_y, in_z, output ready);
endinterface

[sv/agfc_rsp_if.sv]
interface agfc_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] acc_x;
   logic signed [SAMPLE_BITS-1:0] acc_y;
   logic signed [SAMPLE_BITS-1:0] acc_z;
   logic                          accepted;
   logic [2:0]                    calib_status;
   logic [7:0]                    calib_progress;
   logic signed [SAMPLE_BITS-1:0] offset_x;
   logic signed [SAMPLE_BITS-1:0] offset_y;
   logic signed [SAMPLE_BITS-1:0] offset_z;

   modport source (output valid, acc_x, acc_y, acc_z, accepted, calib_status, calib_progress,
                   offset_x, offset_y, offset_z, input ready);
   modport sink   (input valid, acc_x, acc_y, acc_z, accepted, calib_status, calib_progress,
                   offset_x, offset_y, offset_z, output ready);
endinterface

[sv/accel_glitch_filter_calibrator.sv]
// Accelerometer glitch filter and zero-point calibrator.
// req_bus carries one beat per item: a sample, a calibration start, an offset
// load or a calibration cancel, for one port and sensor. rsp_bus returns
// exactly one beat per item: the delivered vector (y negated), whether the
// sample was fresh, the calibration status and progress, and the offset.
// Held vectors live in a synchronous memory, one entry per port and sensor,
// read when the item is accepted and written back when the result is formed.
// An item that does not finish a calibration run passes through the EVAL and
// DONE states from acceptance to a result beat; req is ready only in IDLE.
// The sample that completes a run then goes through a bit-serial divider
// (three axes in parallel), then through the squaring and checking states.
// One item is in work at a time; a new item is taken as soon as the previous
// one's result sits in the output register, even if rsp is still stalled.
// If rsp stalls with a result waiting, the next item finishes and waits.
// Reset (synchronous, active high) holds req off, restores every held vector
// to (0,-1024,0) through per-entry valid bits, clears the offset and the
// calibration state, and loads the register reset values; there is no
// clearing pass. csr writes are taken in any cycle and should be made while idle.
module accel_glitch_filter_calibrator #(
   parameter int NUM_PORTS   = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   agfc_req_if.sink              req_bus,
   agfc_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int NSLOT = 2 * NUM_PORTS;
   localparam int SLW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
   localparam int EW    = (SB + 2 > 17) ? SB + 2 : 17;
   localparam int SW    = SB + 9;
   localparam int NW    = SB + 9;
   localparam int DCW   = $clog2(NW + 1);
   localparam int PW    = 2 * SB;
   localparam int QW    = 2 * SB + 2;
   localparam int RW    = agfc_pkg::REM_W;

   localparam logic signed [EW-1:0] MAXV    = EW'((64'sd1 <<< (SB - 1)) - 1);
   localparam logic signed [EW-1:0] MINV    = -MAXV - EW'(1);
   localparam logic signed [EW-1:0] M_LO    = EW'(agfc_pkg::MAIN_PAT_LO);
   localparam logic signed [EW-1:0] M_HI    = EW'(agfc_pkg::MAIN_PAT_HI);
   localparam logic signed [EW-1:0] X_LO    = EW'(agfc_pkg::EXT_PAT_LO);
   localparam logic signed [EW-1:0] X_HI    = EW'(agfc_pkg::EXT_PAT_HI);
   localparam logic signed [EW-1:0] ONE_G_E = EW'(agfc_pkg::ONE_G);
   localparam logic signed [EW-1:0] HALF_E  = EW'(agfc_pkg::HALF_G);
   localparam logic signed [SB-1:0] REST_YS = SB'(agfc_pkg::REST_Y);
   localparam logic [3*SB-1:0]      REST_V  = {SB'(0), REST_YS, SB'(0)};

   function automatic logic signed [SB-1:0] sat_fn(input logic signed [EW-1:0] v);
      logic signed [SB-1:0] r;
      if (v > MAXV)      r = MAXV[SB-1:0];
      else if (v < MINV) r = MINV[SB-1:0];
      else               r = v[SB-1:0];
      return r;
   endfunction

   // configuration registers
   logic [7:0]  samples_ff;
   logic [12:0] max_dev_ff;
   logic [23:0] min_gsq_ff;
   logic [23:0] max_gsq_ff;
   logic [14:0] plaus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= 8'd90;
         max_dev_ff <= 13'd154;
         min_gsq_ff <= 24'd671089;
         max_gsq_ff <= 24'd1509949;
         plaus_ff   <= 15'd4096;
      end else if (csr_we) begin
         case (csr_index)
            agfc_pkg::REG_SAMPLES: samples_ff <= csr_wdata[7:0];
            agfc_pkg::REG_MAX_DEV: max_dev_ff <= csr_wdata[12:0];
            agfc_pkg::REG_MIN_GSQ: min_gsq_ff <= csr_wdata;
            agfc_pkg::REG_MAX_GSQ: max_gsq_ff <= csr_wdata;
            agfc_pkg::REG_PLAUS:   plaus_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // state
   agfc_pkg::state_type state_ff, state_in;

   logic                 req_fire;
   logic [1:0]           kind_ff;
   logic [1:0]           port_ff;
   logic                 sensor_ff;
   logic                 present_ff;
   logic                 port_ok_ff;
   logic [SLW-1:0]       slot_ff;
   logic signed [SB-1:0] g_ff [3];

   logic                 good_ff, good_in;
   logic signed [SB-1:0] off_ff [3];
   logic signed [SB-1:0] off_in [3];
   logic                 active_ff, active_in;
   logic [1:0]           cport_ff, cport_in;
   logic [7:0]           count_ff, count_in;
   logic signed [SW-1:0] sums_ff [3];
   logic signed [SW-1:0] sums_in [3];
   logic signed [SB-1:0] first_ff [3];
   logic signed [SB-1:0] first_in [3];
   logic                 first_we;
   logic [2:0]           result_ff, result_in;

   // divider and squaring
   logic [8:0]           div_ff, div_in;
   logic [NW-1:0]        num_ff [3];
   logic [NW-1:0]        num_in [3];
   logic [RW-1:0]        rem_ff [3];
   logic [RW-1:0]        rem_in [3];
   logic [NW-1:0]        quo_ff [3];
   logic [NW-1:0]        quo_in [3];
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic [1:0]           sqi_ff, sqi_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [QW-1:0]        sq_ff, sq_in;

   // held vector memory
   logic [3*SB-1:0]      held_mem [NSLOT];
   logic [NSLOT-1:0]     held_vld_ff;
   logic [3*SB-1:0]      rd_ff;
   logic                 rd_vld_ff;
   logic                 wr_en;
   logic [3*SB-1:0]      wr_data;

   // output register
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] o_acc_ff [3];
   logic signed [SB-1:0] o_acc_in [3];
   logic                 o_accepted_ff;
   logic [2:0]           o_status_ff;
   logic [7:0]           o_progress_ff;
   logic signed [SB-1:0] o_off_ff [3];
   logic                 rsp_load;

   assign req_bus.ready = (state_ff == agfc_pkg::S_IDLE) && !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // slot of the incoming beat
   logic [SLW+2:0] req_slot_full;
   logic           req_port_ok;
   assign req_slot_full = {SLW'(0), req_bus.port, req_bus.sensor};
   assign req_port_ok   = (32'(req_bus.port) < NUM_PORTS);

   // capture item, issue memory read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff    <= req_bus.kind;
         port_ff    <= req_bus.port;
         sensor_ff  <= req_bus.sensor;
         present_ff <= req_bus.present;
         port_ok_ff <= req_port_ok;
         slot_ff    <= req_port_ok ? req_slot_full[SLW-1:0] : SLW'(0);
         g_ff[0]    <= req_bus.in_x;
         g_ff[1]    <= req_bus.in_y;
         g_ff[2]    <= req_bus.in_z;
         rd_ff      <= held_mem[req_port_ok ? req_slot_full[SLW-1:0] : SLW'(0)];
         rd_vld_ff  <= held_vld_ff[req_port_ok ? req_slot_full[SLW-1:0] : SLW'(0)];
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) held_mem[slot_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset)      held_vld_ff <= '0;
      else if (wr_en) held_vld_ff[slot_ff] <= 1'b1;
   end

   // glitch test on the captured sample
   logic signed [EW-1:0] ge [3];
   logic [EW-1:0]        gabs [3];
   logic                 is_zero, in_pat, implaus, glitch;
   logic signed [EW-1:0] plo, phi;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ge[i]   = EW'(g_ff[i]);
         gabs[i] = ge[i] < 0 ? EW'(-ge[i]) : EW'(ge[i]);
      end
      plo     = sensor_ff ? X_LO : M_LO;
      phi     = sensor_ff ? X_HI : M_HI;
      is_zero = (g_ff[0] == '0) && (g_ff[1] == '0) && (g_ff[2] == '0);
      in_pat  = (ge[0] >= plo) && (ge[0] <= phi) &&
                (-ge[1] >= plo) && (-ge[1] <= phi) &&
                (-ge[2] >= plo) && (-ge[2] <= phi);
      implaus = !sensor_ff && ((gabs[0] > EW'(plaus_ff)) || (gabs[1] > EW'(plaus_ff)) ||
                               (gabs[2] > EW'(plaus_ff)));
      glitch  = is_zero || in_pat || implaus;
   end

   // mean magnitudes and signs
   logic [SB-1:0]        mag [3];
   logic signed [EW-1:0] mean [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]  = quo_ff[i][SB-1:0];
         mean[i] = sums_ff[i] < 0 ? -EW'(mag[i]) : EW'(mag[i]);
      end
   end

   // main sequencer
   logic                 moved;
   logic [7:0]           cnt_next;
   logic [EW-1:0]        dev;
   logic [SW-1:0]        sabs;
   logic [RW-1:0]        rsh;
   logic                 feed;
   logic signed [EW-1:0] vsub [3];
   logic signed [SB-1:0] v [3];

   always_comb begin
      state_in  = state_ff;
      good_in   = good_ff;
      off_in    = off_ff;
      active_in = active_ff;
      cport_in  = cport_ff;
      count_in  = count_ff;
      sums_in   = sums_ff;
      first_in  = first_ff;
      first_we  = 1'b0;
      result_in = result_ff;
      div_in    = div_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      sqi_in    = sqi_ff;
      prod_in   = prod_ff;
      sq_in     = sq_ff;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      moved     = 1'b0;
      cnt_next  = count_ff + 8'd1;
      feed      = 1'b0;
      dev       = '0;
      sabs      = '0;
      rsh       = '0;

      // delivered vector: the fresh sample, else the held vector, else the rest vector
      for (int i = 0; i < 3; i++) begin
         vsub[i] = EW'(g_ff[i]) - EW'(off_ff[i]);
         v[i]    = sensor_ff ? g_ff[i] : sat_fn(vsub[i]);
      end
      wr_data = {v[2], sat_fn(-EW'(v[1])), v[0]};
      if (kind_ff == agfc_pkg::KIND_SAMPLE && good_ff && port_ok_ff) begin
         o_acc_in[0] = wr_data[SB-1:0];
         o_acc_in[1] = wr_data[2*SB-1:SB];
         o_acc_in[2] = wr_data[3*SB-1:2*SB];
      end else if (port_ok_ff && rd_vld_ff) begin
         o_acc_in[0] = rd_ff[SB-1:0];
         o_acc_in[1] = rd_ff[2*SB-1:SB];
         o_acc_in[2] = rd_ff[3*SB-1:2*SB];
      end else begin
         o_acc_in[0] = REST_V[SB-1:0];
         o_acc_in[1] = REST_V[2*SB-1:SB];
         o_acc_in[2] = REST_V[3*SB-1:2*SB];
      end

      case (state_ff)
         agfc_pkg::S_IDLE: begin
            if (req_fire) state_in = agfc_pkg::S_EVAL;
         end

         agfc_pkg::S_EVAL: begin
            good_in  = present_ff && !glitch;
            state_in = agfc_pkg::S_DONE;
            case (kind_ff)
               agfc_pkg::KIND_SAMPLE: begin
                  feed = present_ff && !glitch && active_ff && !sensor_ff &&
                         (port_ff == cport_ff);
                  if (feed) begin
                     for (int i = 0; i < 3; i++) begin
                        dev = (EW'(g_ff[i]) - EW'(first_ff[i])) < 0 ?
                              EW'(EW'(first_ff[i]) - EW'(g_ff[i])) :
                              EW'(EW'(g_ff[i]) - EW'(first_ff[i]));
                        if (count_ff != 8'd0 && dev > EW'(max_dev_ff)) moved = 1'b1;
                     end
                     if (moved) begin
                        active_in = 1'b0;
                        result_in = agfc_pkg::CAL_MOVED;
                     end else begin
                        if (count_ff == 8'd0) begin
                           first_in = g_ff;
                           first_we = 1'b1;
                        end
                        for (int i = 0; i < 3; i++)
                           sums_in[i] = sums_ff[i] + SW'(g_ff[i]);
                        count_in = cnt_next;
                        if (cnt_next == 8'd0 || cnt_next >= samples_ff) begin
                           div_in = (cnt_next == 8'd0) ? 9'd256 : {1'b0, cnt_next};
                           for (int i = 0; i < 3; i++) begin
                              sabs      = sums_in[i] < 0 ? SW'(-sums_in[i]) : SW'(sums_in[i]);
                              num_in[i] = NW'(sabs) + NW'(div_in[8:1]);
                              rem_in[i] = '0;
                              quo_in[i] = '0;
                           end
                           dcnt_in  = DCW'(NW);
                           state_in = agfc_pkg::S_DIV;
                        end
                     end
                  end
               end
               agfc_pkg::KIND_START: begin
                  count_in = '0;
                  for (int i = 0; i < 3; i++) sums_in[i] = '0;
                  if (port_ok_ff) begin
                     active_in = 1'b1;
                     cport_in  = port_ff;
                     result_in = agfc_pkg::CAL_COLLECTING;
                  end else begin
                     active_in = 1'b0;
                     result_in = agfc_pkg::CAL_CANCELLED;
                  end
               end
               agfc_pkg::KIND_OFFSET: begin
                  off_in = g_ff;
               end
               agfc_pkg::KIND_CANCEL: begin
                  if (active_ff) begin
                     active_in = 1'b0;
                     result_in = agfc_pkg::CAL_CANCELLED;
                  end
               end
               default: ;
            endcase
         end

         // one quotient bit per cycle on all three axes
         agfc_pkg::S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               rsh = {rem_ff[i][RW-2:0], num_ff[i][NW-1]};
               if (rsh >= {1'b0, div_ff}) begin
                  rem_in[i] = rsh - {1'b0, div_ff};
                  quo_in[i] = {quo_ff[i][NW-2:0], 1'b1};
               end else begin
                  rem_in[i] = rsh;
                  quo_in[i] = {quo_ff[i][NW-2:0], 1'b0};
               end
               num_in[i] = {num_ff[i][NW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               sqi_in   = '0;
               prod_in  = '0;
               sq_in    = '0;
               state_in = agfc_pkg::S_SQ;
            end
         end

         // square one axis per cycle, accumulate the registered product
         agfc_pkg::S_SQ: begin
            prod_in = mag[sqi_ff] * mag[sqi_ff];
            sq_in   = sq_ff + QW'(prod_ff);
            sqi_in  = sqi_ff + 2'd1;
            if (sqi_ff == 2'd2) state_in = agfc_pkg::S_CHK;
         end

         agfc_pkg::S_CHK: begin
            active_in = 1'b0;
            if ((sq_ff + QW'(prod_ff)) < QW'(min_gsq_ff) ||
                (sq_ff + QW'(prod_ff)) > QW'(max_gsq_ff) || mean[1] < HALF_E) begin
               result_in = agfc_pkg::CAL_NOT_FLAT;
            end else begin
               off_in[0] = sat_fn(mean[0]);
               off_in[1] = sat_fn(mean[1] - ONE_G_E);
               off_in[2] = sat_fn(mean[2]);
               result_in = agfc_pkg::CAL_DONE;
            end
            state_in = agfc_pkg::S_DONE;
         end

         // write back and hand the beat to the output register
         agfc_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               wr_en    = (kind_ff == agfc_pkg::KIND_SAMPLE) && good_ff && port_ok_ff;
               state_in = agfc_pkg::S_IDLE;
            end
         end

         default: state_in = agfc_pkg::S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= agfc_pkg::S_IDLE;
         active_ff <= 1'b0;
         cport_ff  <= '0;
         count_ff  <= '0;
         result_ff <= agfc_pkg::CAL_IDLE;
         for (int i = 0; i < 3; i++) begin
            off_ff[i]  <= '0;
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         cport_ff  <= cport_in;
         count_ff  <= count_in;
         result_ff <= result_in;
         off_ff    <= off_in;
         sums_ff   <= sums_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      good_ff <= good_in;
      div_ff  <= div_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      sqi_ff  <= sqi_in;
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
      if (first_we) first_ff <= first_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         o_acc_ff      <= o_acc_in;
         o_accepted_ff <= (kind_ff == agfc_pkg::KIND_SAMPLE) && good_ff && port_ok_ff;
         o_status_ff   <= result_ff;
         o_progress_ff <= active_ff ? count_ff : 8'd0;
         o_off_ff      <= off_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.acc_x          = o_acc_ff[0];
   assign rsp_bus.acc_y          = o_acc_ff[1];
   assign rsp_bus.acc_z          = o_acc_ff[2];
   assign rsp_bus.accepted       = o_accepted_ff;
   assign rsp_bus.calib_status   = o_status_ff;
   assign rsp_bus.calib_progress = o_progress_ff;
   assign rsp_bus.offset_x       = o_off_ff[0];
   assign rsp_bus.offset_y       = o_off_ff[1];
   assign rsp_bus.offset_z       = o_off_ff[2];

   // checks
   a_progress_only_collecting: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.calib_progress != 8'd0 |->
      rsp_bus.calib_status == agfc_pkg::CAL_COLLECTING)
      else $error("progress reported outside a calibration run");

   a_active_means_collecting: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> result_ff == agfc_pkg::CAL_COLLECTING)
      else $error("run active with a final status");

   a_accept_starts_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == agfc_pkg::S_EVAL)
      else $error("accepted beat not evaluated");

endmodule
